/* src/nna_pkg.sv */
package nna_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;
    localparam int MODE_BITS      = 2;
    localparam int INDEX_BITS     = 6;
    localparam int DIST_BITS      = 50;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

endpackage

/* src/nna_if.sv */
interface nna_in_if #(
    parameter int COORD_BITS = nna_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [nna_pkg::MODE_BITS-1:0]   mode;
    logic signed [COORD_BITS-1:0]    point_x;
    logic signed [COORD_BITS-1:0]    point_y;

    modport source (output valid, mode, point_x, point_y, input ready);
    modport sink   (input valid, mode, point_x, point_y, output ready);
endinterface

interface nna_out_if;
    logic                            valid;
    logic                            ready;
    logic [nna_pkg::INDEX_BITS-1:0]  nearest_index;
    logic                            found;
    logic [nna_pkg::DIST_BITS-1:0]   min_distance_sq;

    modport source (output valid, nearest_index, found, min_distance_sq, input ready);
    modport sink   (input valid, nearest_index, found, min_distance_sq, output ready);
endinterface

/* src/nna_dist.sv */
module nna_dist #(
    parameter int COORD_BITS = nna_pkg::COORD_BITS_DEF,
    parameter int IDX_W      = nna_pkg::INDEX_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nna_pkg::t_tag                i_tag,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic signed [COORD_BITS-1:0] i_obs_x,
    input  logic signed [COORD_BITS-1:0] i_obs_y,
    input  logic signed [COORD_BITS-1:0] i_ref_x,
    input  logic signed [COORD_BITS-1:0] i_ref_y,
    output nna_pkg::t_tag                o_tag,
    output logic [IDX_W-1:0]             o_idx,
    output logic [2*COORD_BITS+1:0]      o_dist
);

    localparam int D_W  = COORD_BITS + 1;
    localparam int SQ_W = 2 * D_W;

    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic [D_W-1:0]        dxu;
    logic [D_W-1:0]        dyu;
    logic [D_W-1:0]        ax;
    logic [D_W-1:0]        ay;
    logic [SQ_W-1:0]       sqx;
    logic [SQ_W-1:0]       sqy;

    logic [D_W-1:0]        r_ax;
    logic [D_W-1:0]        r_ay;
    logic [SQ_W-1:0]       r_sx;
    logic [SQ_W-1:0]       r_sy;
    logic [SQ_W-1:0]       r_sum;
    nna_pkg::t_tag         r_tag1;
    nna_pkg::t_tag         r_tag2;
    nna_pkg::t_tag         r_tag3;
    logic [IDX_W-1:0]      r_idx1;
    logic [IDX_W-1:0]      r_idx2;
    logic [IDX_W-1:0]      r_idx3;

    // difference and magnitude
    assign dx  = D_W'(i_obs_x) - D_W'(i_ref_x);
    assign dy  = D_W'(i_obs_y) - D_W'(i_ref_y);
    assign dxu = dx;
    assign dyu = dy;
    assign ax  = dxu[D_W-1] ? (~dxu + D_W'(1)) : dxu;
    assign ay  = dyu[D_W-1] ? (~dyu + D_W'(1)) : dyu;

    assign sqx = r_ax * r_ax;
    assign sqy = r_ay * r_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_ax   <= ax;
        r_ay   <= ay;
        r_sx   <= sqx;
        r_sy   <= sqy;
        r_sum  <= r_sx + r_sy;
    end

    assign o_tag  = r_tag3;
    assign o_idx  = r_idx3;
    assign o_dist = r_sum;

endmodule

/* src/nearest_neighbor_association.sv */
// nearest neighbour association over a store of reference points
//
// i_item carries mode, point_x and point_y. mode clear empties the store,
// mode append writes the point at the next free entry (dropped when full),
// mode query scans the store and returns one item on o_result with the
// index of the closest point, found and the squared distance (unsigned,
// saturated at the field's maximum). the unused mode is dropped.
// clear and append are accepted back to back. a query over n stored points
// makes one memory read a cycle in index order; each read then passes the
// read register, three distance stages and the compare stage. an empty
// store answers with found low. i_item is not ready while a query is
// being worked on.
// the result sits in an output register, so a new item is accepted while
// it waits; a finished query holds until that register is free.
// reset empties the store (point count to zero) and drops any pending
// result; the point memory itself is not cleared.
module nearest_neighbor_association #(
    parameter int MAX_POINTS = nna_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nna_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nna_in_if.sink     i_item,
    nna_out_if.source  o_result
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DW    = 2 * COORD_BITS + 2;
    localparam int WW    = (DW > nna_pkg::DIST_BITS) ? DW : nna_pkg::DIST_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                         r_state;
    logic [CNT_W-1:0]               r_count;
    logic [IDX_W-1:0]               r_addr;
    logic signed [COORD_BITS-1:0]   r_obs_x;
    logic signed [COORD_BITS-1:0]   r_obs_y;
    logic [2*COORD_BITS-1:0]        r_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0]        r_rdata;
    nna_pkg::t_tag                  r_rd_tag;
    logic [IDX_W-1:0]               r_rd_idx;
    logic                           r_have;
    logic [DW-1:0]                  r_best;
    logic [IDX_W-1:0]               r_best_idx;
    logic                           r_out_vld;
    logic [nna_pkg::INDEX_BITS-1:0] r_out_idx;
    logic                           r_out_found;
    logic [nna_pkg::DIST_BITS-1:0]  r_out_dist;

    logic                           acc;
    logic                           wr_en;
    logic                           not_full;
    logic                           issue_last;
    nna_pkg::t_tag                  d_tag;
    logic [IDX_W-1:0]               d_idx;
    logic [DW-1:0]                  d_dist;
    logic                           better;
    logic [WW-1:0]                  best_wide;
    logic [nna_pkg::DIST_BITS-1:0]  sat_dist;

    assign i_item.ready = (r_state == S_IDLE);
    assign acc          = i_item.valid && i_item.ready;
    assign not_full     = (r_count < CNT_W'(MAX_POINTS));
    assign wr_en        = acc && (i_item.mode == nna_pkg::MODE_APPEND) && not_full;
    assign issue_last   = (CNT_W'(r_addr) == (r_count - CNT_W'(1)));
    assign better       = d_tag.vld && (!r_have || (d_dist < r_best));
    assign best_wide    = WW'(r_best);
    assign sat_dist     = (best_wide > WW'(nna_pkg::DIST_MAX)) ? nna_pkg::DIST_MAX
                                                              : best_wide[nna_pkg::DIST_BITS-1:0];

    // point store, x in the upper half
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_item.point_x, i_item.point_y};
        end
        r_rdata  <= r_mem[r_addr];
        r_rd_idx <= r_addr;
    end

    nna_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_idx   (r_rd_idx),
        .i_obs_x (r_obs_x),
        .i_obs_y (r_obs_y),
        .i_ref_x (r_rdata[2*COORD_BITS-1:COORD_BITS]),
        .i_ref_y (r_rdata[COORD_BITS-1:0]),
        .o_tag   (d_tag),
        .o_idx   (d_idx),
        .o_dist  (d_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_rd_tag  <= '0;
            r_have    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_tag.vld  <= (r_state == S_SCAN);
            r_rd_tag.last <= (r_state == S_SCAN) && issue_last;
            if (o_result.ready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            if (better) begin
                r_have     <= 1'b1;
                r_best     <= d_dist;
                r_best_idx <= d_idx;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        unique case (i_item.mode)
                            nna_pkg::MODE_CLEAR: begin
                                r_count <= '0;
                            end
                            nna_pkg::MODE_APPEND: begin
                                if (not_full) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            nna_pkg::MODE_QUERY: begin
                                r_obs_x <= i_item.point_x;
                                r_obs_y <= i_item.point_y;
                                r_have  <= 1'b0;
                                r_addr  <= '0;
                                r_state <= (r_count == '0) ? S_OUT : S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + IDX_W'(1);
                    if (issue_last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (d_tag.vld && d_tag.last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || o_result.ready) begin
                        r_out_vld   <= 1'b1;
                        r_out_found <= r_have;
                        r_out_idx   <= r_have ? nna_pkg::INDEX_BITS'(r_best_idx) : '0;
                        r_out_dist  <= r_have ? sat_dist : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.nearest_index   = r_out_idx;
    assign o_result.found           = r_out_found;
    assign o_result.min_distance_sq = r_out_dist;

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.found) |->
            (o_result.nearest_index == '0 && o_result.min_distance_sq == '0))
        else $error("empty query result carries non-zero fields");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_dist_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_tag.vld |-> (r_state == S_SCAN || r_state == S_WAIT))
        else $error("distance item outside a query scan");

    a_scan_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_addr) < r_count))
        else $error("scan address beyond stored points");

endmodule

/* tb/nna_result_checker.sv */
module nna_result_checker
    import nna_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nna_in_if    i_item,
    nna_out_if   i_result,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count
);

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  found;
        logic [DIST_BITS-1:0]  dist_sq;
    } t_nearest;

    logic signed [COORD_BITS-1:0] ref_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] ref_y [MAX_POINTS];
    int unsigned                  point_total = 0;
    t_nearest                     nearest_q [$];
    int                           fails = 0;
    int                           results = 0;
    t_nearest                     got;
    t_nearest                     want;

    // scan in index order, only a strictly closer point replaces the best
    function automatic t_nearest nearest_point(input logic signed [COORD_BITS-1:0] qx,
                                               input logic signed [COORD_BITS-1:0] qy);
        t_nearest          best;
        longint            dx;
        longint            dy;
        longint unsigned   d;
        longint unsigned   best_d;
        best   = '0;
        best_d = 0;
        for (int j = 0; j < int'(point_total); j++) begin
            dx = longint'(qx) - longint'(ref_x[j]);
            dy = longint'(qy) - longint'(ref_y[j]);
            d  = longint'(dx * dx + dy * dy);
            if (!best.found || d < best_d) begin
                best_d     = d;
                best.index = INDEX_BITS'(j);
                best.found = 1'b1;
            end
        end
        best.dist_sq = (best_d > DIST_MAX) ? DIST_MAX : best_d[DIST_BITS-1:0];
        return best;
    endfunction

    task automatic report(input string what, input t_nearest exp_r, input t_nearest act_r);
        fails++;
        if (fails <= 10) begin
            $display("%s: exp index %0d found %0d dist %0d, got index %0d found %0d dist %0d",
                     what, exp_r.index, exp_r.found, exp_r.dist_sq,
                     act_r.index, act_r.found, act_r.dist_sq);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_total = 0;
            nearest_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got = '{index: i_result.nearest_index, found: i_result.found,
                        dist_sq: i_result.min_distance_sq};
                results++;
                if (nearest_q.size() == 0) begin
                    report("unexpected result", '0, got);
                end else begin
                    want = nearest_q.pop_front();
                    if (got !== want) begin
                        report("wrong result", want, got);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                case (t_mode'(i_item.mode))
                    MODE_CLEAR: begin
                        point_total = 0;
                    end
                    MODE_APPEND: begin
                        if (point_total < MAX_POINTS) begin
                            ref_x[point_total] = i_item.point_x;
                            ref_y[point_total] = i_item.point_y;
                            point_total++;
                        end
                    end
                    MODE_QUERY: begin
                        nearest_q = {nearest_q,
                                     nearest_point(i_item.point_x, i_item.point_y)};
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count   <= fails;
        o_pending      <= nearest_q.size();
        o_result_count <= results;
    end

endmodule

/* tb/tb_nearest_neighbor_association.sv */
module tb_nearest_neighbor_association;
    import nna_pkg::*;

    localparam int MAX_POINTS   = MAX_POINTS_DEF;
    localparam int COORD        = COORD_BITS_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam int LIMIT        = 1_000_000;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef logic signed [COORD-1:0] t_coord;

    localparam t_coord COORD_MAX = {1'b0, {(COORD-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD-1){1'b0}}};

    logic i_clk;
    logic i_rst_n;

    nna_in_if #(.COORD_BITS(COORD)) item_ch ();
    nna_out_if                      result_ch ();

    int fail_count;
    int pending;
    int result_count;

    nearest_neighbor_association #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    nna_result_checker #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD)
    ) u_result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item_ch),
        .i_result       (result_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    bit          calm = 1'b0;
    bit          item_held = 1'b0;
    int unsigned next_gap = 0;
    int unsigned held_points = 0;
    int          sent_count = 0;
    int          ignored_count = 0;
    int          query_count = 0;
    int          empty_queries = 0;
    int          full_appends = 0;
    int          cycle_count = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("timed out after %0d cycles", cycle_count);
            $display("nearest_neighbor_association: mismatch");
            $finish;
        end
    end

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic t_coord pick_coord(input int unsigned style, input t_coord centre);
        case (style)
            0: return t_coord'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    3: return '1;
                    default: return t_coord'(1);
                endcase
            end
            default: return centre + t_coord'($urandom_range(0, 64)) - t_coord'(32);
        endcase
    endfunction

    task automatic send_item(input logic [MODE_BITS-1:0] m, input t_coord x, input t_coord y);
        repeat (next_gap) @(posedge i_clk);
        item_ch.valid   <= 1'b1;
        item_ch.mode    <= m;
        item_ch.point_x <= x;
        item_ch.point_y <= y;
        do @(posedge i_clk); while (!item_ch.ready);
        next_gap = draw_wait();
        if (next_gap > 0) begin
            item_ch.valid <= 1'b0;
            item_held = 1'b0;
        end else begin
            item_held = 1'b1;
        end
        if (m == MODE_QUERY) begin
            query_count++;
            if (held_points == 0) empty_queries++;
        end
        if (m == MODE_CLEAR) held_points = 0;
        if (m == MODE_UNUSED || (m == MODE_APPEND && held_points >= MAX_POINTS)) begin
            ignored_count++;
            if (m == MODE_APPEND) full_appends++;
        end else begin
            sent_count++;
            if (m == MODE_APPEND) held_points++;
        end
    endtask

    task automatic stop_items();
        if (item_held) begin
            item_ch.valid <= 1'b0;
            item_held = 1'b0;
        end
    endtask

    task automatic wait_drained();
        stop_items();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // clear (usually), fill with a batch of points, then query at some of them or at new picks
    task automatic run_sequence();
        t_coord      xs [$];
        t_coord      ys [$];
        t_coord      cx;
        t_coord      cy;
        t_coord      px;
        t_coord      py;
        int unsigned style;
        int unsigned n;
        int unsigned q;
        int unsigned k;
        calm  = ($urandom_range(0, 4) == 0);
        style = $urandom_range(0, 2);
        cx    = t_coord'($urandom);
        cy    = t_coord'($urandom);
        if ($urandom_range(0, 3) != 0) send_item(MODE_CLEAR, t_coord'($urandom),
                                                 t_coord'($urandom));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 8);
        for (int i = 0; i < int'(n); i++) begin
            if (xs.size() > 0 && $urandom_range(0, 5) == 0) begin
                px = xs[xs.size()-1];
                py = ys[ys.size()-1];
            end else begin
                px = pick_coord(style, cx);
                py = pick_coord(style, cy);
            end
            xs = {xs, px};
            ys = {ys, py};
            send_item(MODE_APPEND, px, py);
        end
        q = $urandom_range(1, 6);
        for (int i = 0; i < int'(q); i++) begin
            if (xs.size() > 0 && $urandom_range(0, 2) == 0) begin
                k  = $urandom_range(0, xs.size() - 1);
                px = xs[k];
                py = ys[k];
            end else begin
                px = pick_coord(style, cx);
                py = pick_coord(style, cy);
            end
            send_item(MODE_QUERY, px, py);
        end
    endtask

    initial begin
        int unsigned stall;
        result_ch.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    initial begin
        int unsigned sel;
        int unsigned k;
        item_ch.valid   = 1'b0;
        item_ch.mode    = MODE_CLEAR;
        item_ch.point_x = '0;
        item_ch.point_y = '0;
        i_rst_n         = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, ties, unused mode, empty store
        send_item(MODE_QUERY, '0, '0);
        send_item(MODE_APPEND, COORD_MAX, COORD_MAX);
        send_item(MODE_APPEND, COORD_MIN, COORD_MIN);
        send_item(MODE_QUERY, COORD_MAX, COORD_MAX);
        send_item(MODE_QUERY, COORD_MIN, COORD_MIN);
        send_item(MODE_QUERY, COORD_MIN, COORD_MAX);
        send_item(MODE_UNUSED, COORD_MAX, COORD_MIN);
        send_item(MODE_QUERY, '0, '0);
        send_item(MODE_CLEAR, '0, '0);
        send_item(MODE_QUERY, COORD_MIN, COORD_MIN);
        send_item(MODE_APPEND, COORD_MAX, COORD_MAX);
        send_item(MODE_QUERY, COORD_MIN, COORD_MIN);
        send_item(MODE_APPEND, '1, t_coord'(1));
        send_item(MODE_APPEND, '1, t_coord'(1));
        send_item(MODE_APPEND, t_coord'(1), '1);
        send_item(MODE_QUERY, '1, t_coord'(1));
        send_item(MODE_QUERY, '0, '0);
        send_item(MODE_UNUSED, '0, '0);
        send_item(MODE_CLEAR, COORD_MIN, COORD_MAX);
        send_item(MODE_QUERY, '0, '0);
        wait_drained();

        while (sent_count < RANDOM_ITEMS + 20) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                run_sequence();
            end else if (sel == 7) begin
                wait_drained();
            end else begin
                calm = 1'b0;
                k = $urandom_range(1, 4);
                for (int i = 0; i < int'(k); i++) begin
                    send_item(MODE_BITS'($urandom_range(0, 3)), t_coord'($urandom),
                              t_coord'($urandom));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d items (%0d queries, %0d on an empty store), %0d ignored",
                 sent_count, query_count, empty_queries, ignored_count);
        $display("%0d appends hit a full store, %0d results compared",
                 full_appends, result_count);
        if (fail_count == 0) begin
            $display("nearest_neighbor_association: match");
        end else begin
            $display("nearest_neighbor_association: mismatch");
        end
        $finish;
    end

endmodule
